[rtl/feedback_send_rate_controller_unit_assert.svh]
// ----------------------------------------------------------------------------
// feedback send rate controller assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_SEND_RATE_CONTROLLER_UNIT_ASSERT_SVH
`define FEEDBACK_SEND_RATE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define FSRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsrc assertion failed");

// next-cycle implication
`define FSRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsrc assertion failed");

`endif

[rtl/fsrc_pkg.sv]
// ----------------------------------------------------------------------------
// fsrc_pkg
// widths, register map, mode codes and reset values of the rate controller
// ----------------------------------------------------------------------------
package fsrc_pkg;

  localparam int LEVEL_WIDTH = 24;
  localparam int RATE_W      = 32;
  localparam int GAIN_W      = 24;
  localparam int MODE_W      = 2;

  // serial multiplier: gain digits times a wide operand
  localparam int OPND_W      = 32;
  localparam int DIGIT_W     = 2;
  localparam int MUL_STEPS   = GAIN_W / DIGIT_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int PROD_W      = GAIN_W + OPND_W;

  localparam int LTERM_SHIFT = 8;
  localparam int DTERM_SHIFT = 24;
  localparam int LMAG_W      = PROD_W - LTERM_SHIFT;
  localparam int DMAG_W      = PROD_W - DTERM_SHIFT;
  localparam int BASE_W      = RATE_W + 2;
  localparam int CAND_W      = LMAG_W + 2;

  // spacing divider, numerator is SPACING_NUM << RATE_W
  localparam int SPACING_NUM = 1000;
  localparam int DIV_STEPS   = RATE_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // apb
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INIT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DECR  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LGAIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DGAIN = 3'd5;

  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AIMD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DAMP = 2'd3;

  localparam logic [MODE_W-1:0] MODE_RST  = MODE_ADD;
  localparam logic [RATE_W-1:0] INIT_RST  = 32'd65536000;
  localparam logic [RATE_W-1:0] STEP_RST  = 32'd65536;
  localparam logic [GAIN_W-1:0] DECR_RST  = 24'd8388608;
  localparam logic [GAIN_W-1:0] LGAIN_RST = 24'd16777;
  localparam logic [GAIN_W-1:0] DGAIN_RST = 24'd8388608;

endpackage

[rtl/fsrc_if.sv]
// ----------------------------------------------------------------------------
// fsrc channel interfaces
// feedback word in, rate result word out, valid/ready handshake
// ----------------------------------------------------------------------------
interface fsrc_fb_if;
  import fsrc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [LEVEL_WIDTH-1:0] current_level;
  logic [LEVEL_WIDTH-1:0] target_level;
  logic [RATE_W-1:0]      target_rate;

  modport source (output valid, output current_level, output target_level,
                  output target_rate, input ready);
  modport sink   (input valid, input current_level, input target_level,
                  input target_rate, output ready);
endinterface

interface fsrc_res_if;
  import fsrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] new_rate;
  logic [RATE_W-1:0] spacing_ms;
  logic              rate_changed;

  modport source (output valid, output new_rate, output spacing_ms,
                  output rate_changed, input ready);
  modport sink   (input valid, input new_rate, input spacing_ms,
                  input rate_changed, output ready);
endinterface

[rtl/fsrc_mul.sv]
// ----------------------------------------------------------------------------
// fsrc_mul
// serial-parallel multiplier, two gain bits per cycle, lsb first
// ----------------------------------------------------------------------------
module fsrc_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fsrc_pkg::GAIN_W-1:0]   gain,
  input  logic [fsrc_pkg::OPND_W-1:0]   opnd,
  output logic                          done,
  output logic [fsrc_pkg::PROD_W-1:0]   prod
);
  import fsrc_pkg::*;

  logic                 busy;
  logic                 prep;
  logic [MUL_CNT_W-1:0] cnt;
  logic [OPND_W-1:0]    b;
  logic [OPND_W+1:0]    b3;
  logic [GAIN_W-1:0]    g;
  logic [OPND_W-1:0]    acc;
  logic [GAIN_W-1:0]    lo;
  logic [OPND_W+1:0]    addend;
  logic [OPND_W+1:0]    sum;

  always_comb begin
    unique case (g[DIGIT_W-1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, b};
      2'd2:    addend = {1'b0, b, 1'b0};
      default: addend = b3;
    endcase
    sum = {2'b00, acc} + addend;
  end

  assign prod = {acc, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      prep <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        prep <= 1'b1;
        cnt  <= '0;
      end else if (prep) begin
        prep <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      b   <= opnd;
      g   <= gain;
      acc <= '0;
      lo  <= '0;
    end else if (prep) begin
      // triple of the operand for digit 3
      b3 <= {2'b00, b} + {1'b0, b, 1'b0};
    end else if (busy) begin
      acc <= sum[OPND_W+1:DIGIT_W];
      lo  <= {sum[DIGIT_W-1:0], lo[GAIN_W-1:DIGIT_W]};
      g   <= g >> DIGIT_W;
    end
  end

endmodule

[rtl/fsrc_div.sv]
// ----------------------------------------------------------------------------
// fsrc_div
// restoring divider for spacing, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fsrc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fsrc_pkg::RATE_W-1:0] divisor,
  output logic                        done,
  output logic [fsrc_pkg::RATE_W-1:0] quot
);
  import fsrc_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W-1:0]    rem;
  logic [RATE_W-1:0]    dvs;
  logic [RATE_W:0]      shifted;
  logic [RATE_W+1:0]    diff;
  logic                 ge;

  // rem stays below dvs, so the shifted value fits
  assign shifted = {rem, 1'b0};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};
  assign ge      = ~diff[RATE_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        // quotient would not fit: saturate at once
        if (divisor <= RATE_W'(SPACING_NUM)) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= RATE_W'(SPACING_NUM);
      dvs  <= divisor;
      quot <= '1;
    end else if (busy) begin
      rem  <= ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
      quot <= {quot[RATE_W-2:0], ge};
    end
  end

endmodule

[rtl/feedback_send_rate_controller_unit.sv]
// ----------------------------------------------------------------------------
// feedback send rate controller
// Takes one receiver feedback word (buffer level, target level, target rate)
// at a time and updates a Q16.16 packet rate under the mode in control_mode:
// additive, additive-up/multiplicative-down, proportional to the level error,
// or proportional with damping toward target_rate. Each word gives one result
// word with the new rate, the spacing 1000/rate in Q16.16 ms (saturated) and
// a flag telling whether the rate was updated. From accept to result a word
// passes the setup steps, the two serial multipliers that run side by side on
// two gain bits per cycle, the steps that form and apply the new rate, the
// bit-serial spacing divider (which ends at once when the raw rate is 1000
// or less and the spacing saturates), and the load of the output register.
// One word is in flight at a time; a new feedback word is taken while a
// finished result still waits in the output register. Registers sit on the
// apb port at byte address 4*i; a write of initial_rate also loads the
// running rate.
// ----------------------------------------------------------------------------
module feedback_send_rate_controller_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsrc_pkg::PADDR_W-1:0] paddr,
  input  logic [fsrc_pkg::PDATA_W-1:0] pwdata,
  output logic [fsrc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  fsrc_fb_if.sink                      fb,
  fsrc_res_if.source                   res
);
  import fsrc_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_TERM   = 3'd3;
  localparam logic [2:0] ST_COMB   = 3'd4;
  localparam logic [2:0] ST_DSTART = 3'd5;
  localparam logic [2:0] ST_DIV    = 3'd6;
  localparam logic [2:0] ST_LOAD   = 3'd7;

  // configuration registers
  logic [MODE_W-1:0] control_mode;
  logic [RATE_W-1:0] initial_rate;
  logic [RATE_W-1:0] additive_step;
  logic [GAIN_W-1:0] decrease_factor;
  logic [GAIN_W-1:0] level_gain;
  logic [GAIN_W-1:0] damping_gain;

  logic [RATE_W-1:0] rate;
  logic [2:0]        state;

  // per-word working registers
  logic [LEVEL_WIDTH:0] err;       // target - current, two's complement
  logic [RATE_W:0]      dif;       // rate - target_rate, two's complement
  logic [BASE_W-1:0]    base;      // rate minus damping term
  logic                 chg;

  // output register
  logic              out_valid;
  logic [RATE_W-1:0] out_rate;
  logic [RATE_W-1:0] out_spacing;
  logic              out_chg;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 fb_take;
  logic                 out_load;

  logic                 err_neg;
  logic                 err_pos;
  logic                 dif_neg;
  logic [LEVEL_WIDTH:0] err_inv;
  logic [RATE_W:0]      dif_inv;
  logic [LEVEL_WIDTH-1:0] abs_err;
  logic [RATE_W-1:0]    abs_dif;

  logic                 mul_start;
  logic [GAIN_W-1:0]    aux_gain;
  logic [OPND_W-1:0]    aux_opnd;
  logic [PROD_W-1:0]    prod_lvl;
  logic [PROD_W-1:0]    prod_aux;
  logic                 lvl_done;
  logic                 aux_done;
  logic [LMAG_W-1:0]    lmag;
  logic [DMAG_W-1:0]    dmag;

  logic [CAND_W-1:0]    base_x;
  logic [CAND_W-1:0]    cand_lvl;
  logic [CAND_W-1:0]    cand_up;
  logic [CAND_W-1:0]    cand_dn;
  logic [CAND_W-1:0]    cand;
  logic                 cand_pos;
  logic                 apply;
  logic [RATE_W-1:0]    rate_upd;

  logic                 div_start;
  logic                 div_done;
  logic [RATE_W-1:0]    quot;

  // ---------------------------------------------------------------- apb port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:  prdata = PDATA_W'(control_mode);
      REG_INIT:  prdata = PDATA_W'(initial_rate);
      REG_STEP:  prdata = PDATA_W'(additive_step);
      REG_DECR:  prdata = PDATA_W'(decrease_factor);
      REG_LGAIN: prdata = PDATA_W'(level_gain);
      REG_DGAIN: prdata = PDATA_W'(damping_gain);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode    <= MODE_RST;
      initial_rate    <= INIT_RST;
      additive_step   <= STEP_RST;
      decrease_factor <= DECR_RST;
      level_gain      <= LGAIN_RST;
      damping_gain    <= DGAIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:  control_mode    <= pwdata[MODE_W-1:0];
        REG_INIT:  initial_rate    <= pwdata[RATE_W-1:0];
        REG_STEP:  additive_step   <= pwdata[RATE_W-1:0];
        REG_DECR:  decrease_factor <= pwdata[GAIN_W-1:0];
        REG_LGAIN: level_gain      <= pwdata[GAIN_W-1:0];
        REG_DGAIN: damping_gain    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- sequencer
  assign fb.ready = (state == ST_IDLE);
  assign fb_take  = fb.valid & fb.ready;
  assign out_load = (state == ST_LOAD) & (~out_valid | res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:   if (fb_take) state <= ST_PREP;
        ST_PREP:   state <= ST_MUL;
        ST_MUL:    if (lvl_done & aux_done) state <= ST_TERM;
        ST_TERM:   state <= ST_COMB;
        ST_COMB:   state <= ST_DSTART;
        ST_DSTART: state <= ST_DIV;
        ST_DIV:    if (div_done) state <= ST_LOAD;
        ST_LOAD:   if (out_load) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // level error and distance to target rate, taken at accept
  always_ff @(posedge clk) begin
    if (fb_take) begin
      err <= {1'b0, fb.target_level} - {1'b0, fb.current_level};
      dif <= {1'b0, rate} - {1'b0, fb.target_rate};
    end
  end

  assign err_neg = err[LEVEL_WIDTH];
  assign err_pos = ~err_neg & (|err);
  assign dif_neg = dif[RATE_W];
  assign err_inv = -err;
  assign dif_inv = -dif;
  assign abs_err = err_neg ? err_inv[LEVEL_WIDTH-1:0] : err[LEVEL_WIDTH-1:0];
  assign abs_dif = dif_neg ? dif_inv[RATE_W-1:0] : dif[RATE_W-1:0];

  // ------------------------------------------------------------ multipliers
  // level term on one unit; damping term or the mode 1 decrease on the other
  assign mul_start = (state == ST_PREP);
  assign aux_gain  = (control_mode == MODE_AIMD) ? decrease_factor : damping_gain;
  assign aux_opnd  = (control_mode == MODE_AIMD) ? OPND_W'(rate) : OPND_W'(abs_dif);

  fsrc_mul u_mul_lvl (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .gain  (level_gain),
    .opnd  (OPND_W'(abs_err)),
    .done  (lvl_done),
    .prod  (prod_lvl)
  );

  fsrc_mul u_mul_aux (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .gain  (aux_gain),
    .opnd  (aux_opnd),
    .done  (aux_done),
    .prod  (prod_aux)
  );

  assign lmag = prod_lvl[PROD_W-1:LTERM_SHIFT];
  assign dmag = prod_aux[PROD_W-1:DTERM_SHIFT];

  // rate minus the damping term, signed; plain rate outside mode 3
  always_ff @(posedge clk) begin
    if (state == ST_TERM) begin
      if (control_mode == MODE_DAMP) begin
        base <= dif_neg ? ({2'b00, rate} + {2'b00, dmag})
                        : ({2'b00, rate} - {2'b00, dmag});
      end else begin
        base <= {2'b00, rate};
      end
    end
  end

  // --------------------------------------------------------- rate candidate
  assign base_x   = {{(CAND_W - BASE_W){base[BASE_W-1]}}, base};
  assign cand_lvl = err_neg ? (base_x - CAND_W'(lmag)) : (base_x + CAND_W'(lmag));
  assign cand_up  = CAND_W'(rate) + CAND_W'(additive_step);
  assign cand_dn  = CAND_W'(rate) - CAND_W'(additive_step);

  always_comb begin
    cand  = cand_lvl;
    apply = 1'b0;
    priority if (err_pos) begin
      unique case (control_mode)
        MODE_ADD, MODE_AIMD: begin
          cand  = cand_up;
          apply = 1'b1;
        end
        MODE_PROP: begin
          cand  = cand_lvl;
          apply = 1'b1;
        end
        default: begin
          cand  = cand_lvl;
          apply = cand_pos;
        end
      endcase
    end else if (err_neg) begin
      unique case (control_mode)
        MODE_ADD:  cand = cand_dn;
        MODE_AIMD: cand = CAND_W'(dmag);
        default:   cand = cand_lvl;
      endcase
      apply = cand_pos;
    end else begin
      apply = 1'b0;
    end
  end

  assign cand_pos = ~cand[CAND_W-1] & (|cand);
  // saturate above the rate range; a negative candidate is never applied
  assign rate_upd = (|cand[CAND_W-2:RATE_W]) ? '1 : cand[RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= INIT_RST;
    end else if (cfg_wr && cfg_idx == REG_INIT) begin
      rate <= pwdata[RATE_W-1:0];
    end else if (state == ST_COMB && apply) begin
      rate <= rate_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COMB) begin
      chg <= apply;
    end
  end

  // ---------------------------------------------------------------- spacing
  assign div_start = (state == ST_DSTART);

  fsrc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (rate),
    .done    (div_done),
    .quot    (quot)
  );

  // ---------------------------------------------------------- result output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate    <= rate;
      out_spacing <= quot;
      out_chg     <= chg;
    end
  end

  assign res.valid        = out_valid;
  assign res.new_rate     = out_rate;
  assign res.spacing_ms   = out_spacing;
  assign res.rate_changed = out_chg;

endmodule

[rtl/fsrc_checker.sv]
// ----------------------------------------------------------------------------
// fsrc_checker
// port-level checks of the rate controller, bound to the top level
// ----------------------------------------------------------------------------
`include "feedback_send_rate_controller_unit_assert.svh"

module fsrc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        fb_valid,
  input logic                        fb_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [fsrc_pkg::RATE_W-1:0] new_rate,
  input logic [fsrc_pkg::RATE_W-1:0] spacing_ms,
  input logic                        rate_changed
);
  import fsrc_pkg::*;

  // one word in flight: no accept right after an accept
  `FSRC_ASSERT_NEXT(a_one_in_flight, clk, rst, fb_valid && fb_ready, !fb_ready)

  // spacing saturates exactly when the rate is at or below SPACING_NUM
  `FSRC_ASSERT_IMP(a_spacing_sat, clk, rst, res_valid,
    (new_rate <= RATE_W'(SPACING_NUM)) == (spacing_ms == '1))

  // a stalled result word holds
  `FSRC_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(new_rate) && $stable(spacing_ms) && $stable(rate_changed))

endmodule

bind feedback_send_rate_controller_unit fsrc_checker u_fsrc_checker (
  .clk          (clk),
  .rst          (rst),
  .fb_valid     (fb.valid),
  .fb_ready     (fb.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .new_rate     (res.new_rate),
  .spacing_ms   (res.spacing_ms),
  .rate_changed (res.rate_changed)
);
